// File: src/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler converter
// Fixed widths of the datapath, angle constants and the CORDIC arctangent
// table in units of 2^-30 rad.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int W_IN   = 16;
    localparam int W_PROD = 32;
    localparam int W_SUM  = 35;
    localparam int W_SQ   = 58;
    localparam int W_REM  = 59;
    localparam int W_ROOT = 29;
    localparam int W_VEC  = 38;
    localparam int W_ANG  = 34;
    localparam int W_OUT  = 16;
    localparam int W_DEGP = 66;
    localparam int TAB_LEN = 24;

    localparam logic signed [W_SUM-1:0] ONE_Q28 = 35'sd268435456;
    localparam logic [W_SQ-1:0] ONE_Q56  = 58'd1 << 56;
    localparam logic [W_SQ-1:0] HALF_Q56 = 58'd1 << 55;
    localparam logic [W_SQ-1:0] SMALL_COS_SQ = 58'd7205759403792;
    localparam logic signed [W_ANG-1:0] HALF_PI_A = 34'sd1686629713;
    localparam logic signed [W_ANG-1:0] PI_A      = 34'sd3373259426;
    localparam logic signed [30:0] DEG_MUL = 31'sd961263669;

    typedef struct packed {
        logic [W_REM-1:0]  rem;
        logic [W_ROOT-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [W_VEC-1:0] x;
        logic signed [W_VEC-1:0] y;
        logic signed [W_ANG-1:0] z;
        logic                    done;
    } t_vec;

    typedef struct packed {
        logic then_br;
        logic pitch_zero;
        logic pitch_neg;
        logic yaw_zero;
    } t_tag;

    function automatic logic [31:0] atan_tab(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd843314856;
            1:  v = 32'd497837829;
            2:  v = 32'd263043836;
            3:  v = 32'd133525158;
            4:  v = 32'd67021686;
            5:  v = 32'd33543515;
            6:  v = 32'd16775850;
            7:  v = 32'd8388437;
            8:  v = 32'd4194282;
            9:  v = 32'd2097149;
            10: v = 32'd1048575;
            11: v = 32'd524287;
            12: v = 32'd262143;
            13: v = 32'd131071;
            14: v = 32'd65535;
            15: v = 32'd32767;
            16: v = 32'd16383;
            17: v = 32'd8191;
            18: v = 32'd4095;
            19: v = 32'd2047;
            20: v = 32'd1023;
            21: v = 32'd511;
            22: v = 32'd255;
            23: v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/qte_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one result bit of a pipelined floor square root
// Tries bit K of the root against the partial remainder and registers both.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  qte_pkg::t_sqrt i_d,
    output qte_pkg::t_sqrt o_d
);

    logic [qte_pkg::W_REM-1:0] w_trial;
    qte_pkg::t_sqrt n_d;
    qte_pkg::t_sqrt r_d;

    always_comb begin
        w_trial = (qte_pkg::W_REM'(i_d.root) << (K + 1)) + (qte_pkg::W_REM'(1) << (2 * K));
        n_d = i_d;
        if (i_d.rem >= w_trial) begin
            n_d.rem  = i_d.rem - w_trial;
            n_d.root = i_d.root | (qte_pkg::W_ROOT'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: src/qte_cordic_cell.sv
// ----------------------------------------------------------------------------
// qte_cordic_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-SHIFT) and accumulates the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  qte_pkg::t_vec i_d,
    output qte_pkg::t_vec o_d
);

    logic signed [qte_pkg::W_VEC-1:0] w_dx;
    logic signed [qte_pkg::W_VEC-1:0] w_dy;
    logic signed [qte_pkg::W_ANG-1:0] w_ang;
    qte_pkg::t_vec n_d;
    qte_pkg::t_vec r_d;

    always_comb begin
        w_dx  = i_d.y >>> SHIFT;
        w_dy  = i_d.x >>> SHIFT;
        w_ang = {2'b00, qte_pkg::atan_tab(SHIFT)};
        n_d   = i_d;
        // hold a finished angle
        if (!i_d.done) begin
            if (i_d.y > 0) begin
                n_d.x = i_d.x + w_dx;
                n_d.y = i_d.y - w_dy;
                n_d.z = i_d.z + w_ang;
            end else begin
                n_d.x = i_d.x - w_dx;
                n_d.y = i_d.y + w_dy;
                n_d.z = i_d.z - w_ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: src/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic: pipelined atan2 in units of 2^-30 rad
// A quadrant stage followed by STAGES vectoring cells.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [qte_pkg::W_SUM-1:0] i_y,
    input  logic signed [qte_pkg::W_SUM-1:0] i_x,
    output logic signed [qte_pkg::W_ANG-1:0] o_z
);

    logic signed [qte_pkg::W_VEC-1:0] w_y;
    logic signed [qte_pkg::W_VEC-1:0] w_x;
    qte_pkg::t_vec n_pre;
    qte_pkg::t_vec r_pre;
    qte_pkg::t_vec w_v [0:STAGES];

    always_comb begin
        w_y = qte_pkg::W_VEC'(i_y);
        w_x = qte_pkg::W_VEC'(i_x);
        n_pre.x    = w_x;
        n_pre.y    = w_y;
        n_pre.z    = '0;
        n_pre.done = 1'b0;
        if (w_y == '0) begin
            n_pre.done = 1'b1;
            n_pre.z    = (w_x < 0) ? qte_pkg::PI_A : '0;
        end else if (w_x < 0) begin
            // fold into the right half plane
            if (w_y > 0) begin
                n_pre.x = w_y;
                n_pre.y = -w_x;
                n_pre.z = qte_pkg::HALF_PI_A;
            end else begin
                n_pre.x = -w_y;
                n_pre.y = w_x;
                n_pre.z = -qte_pkg::HALF_PI_A;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    assign w_v[0] = r_pre;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        qte_cordic_cell #(
            .SHIFT(g)
        ) u_cell (
            .i_clk(i_clk),
            .i_en (i_en),
            .i_d  (w_v[g]),
            .o_d  (w_v[g+1])
        );
    end

    assign o_z = w_v[STAGES].z;

endmodule

// File: src/quaternion_to_euler_angles_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core: quaternion to roll, pitch and yaw
// Fully pipelined converter: one quaternion (Q2.14) in, three angles out in
// radians Q3.13 or degrees Q9.7, one item per cycle unless output stalls.
// Data passes the product, term, square and branch stages, 29 square-root
// cells, the CORDIC quadrant stage, CORDIC_STAGES vectoring cells and the
// fixup, product and output registers. The whole pipeline holds only while
// a result waits at the output. The user must write the angle unit setting
// between bursts, when the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // comp_x, comp_y, comp_z, comp_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data     // angle_in_degrees
);

    localparam int SQ_CELLS = qte_pkg::W_ROOT;
    localparam int LAT      = 4 + SQ_CELLS + CORDIC_STAGES + 1 + 3;

    logic r_deg;
    logic w_en;
    logic [LAT-1:0] r_vld;

    // products
    logic signed [qte_pkg::W_PROD-1:0] r_xx, r_yy, r_zz, r_wy, r_zx, r_zy, r_wx, r_wz,
                                       r_xy, r_yz;
    // sums
    logic signed [qte_pkg::W_SUM-1:0] r_s, r_m12, r_m22, r_yn, r_yd, r_m21, r_m11;
    // squares
    logic signed [qte_pkg::W_SUM-1:0] r3_s, r3_m12, r3_m22, r3_yn, r3_yd, r3_m21, r3_m11;
    logic [qte_pkg::W_SQ-1:0] r3_ssq, r3_m12sq, r3_m22sq;
    logic r3_s_small, r3_m_small;
    // decision
    logic [qte_pkg::W_SQ-1:0] w_q;
    logic w_then, w_big, w_norm;
    qte_pkg::t_sqrt n_sqa, n_sqb, r_sqa, r_sqb;
    qte_pkg::t_tag n_tag, r_tag;
    logic signed [qte_pkg::W_SUM-1:0] n_ry, n_rx, r_ry, r_rx, r_yn4, r_yd4, r_s4;

    // delay line beside the square roots
    qte_pkg::t_tag r_dtag [0:SQ_CELLS-1];
    logic signed [qte_pkg::W_SUM-1:0] r_dry [0:SQ_CELLS-1];
    logic signed [qte_pkg::W_SUM-1:0] r_drx [0:SQ_CELLS-1];
    logic signed [qte_pkg::W_SUM-1:0] r_dyn [0:SQ_CELLS-1];
    logic signed [qte_pkg::W_SUM-1:0] r_dyd [0:SQ_CELLS-1];
    logic signed [qte_pkg::W_SUM-1:0] r_ds  [0:SQ_CELLS-1];
    qte_pkg::t_tag r_ctag [0:CORDIC_STAGES];

    qte_pkg::t_sqrt w_sa [0:SQ_CELLS];
    qte_pkg::t_sqrt w_sb [0:SQ_CELLS];

    logic signed [qte_pkg::W_SUM-1:0] w_py, w_px, w_ra, w_rb;
    logic signed [qte_pkg::W_ANG-1:0] w_zr, w_zp, w_zy;
    logic signed [qte_pkg::W_ANG-1:0] r_fix [0:2];
    logic signed [qte_pkg::W_ANG-1:0] r_ang [0:2];
    logic signed [qte_pkg::W_DEGP-1:0] r_prod [0:2];
    logic [qte_pkg::W_OUT-1:0] n_out [0:2];
    logic [qte_pkg::W_OUT-1:0] r_out [0:2];

    function automatic logic [qte_pkg::W_OUT-1:0] scale_out(
        input logic                              deg,
        input logic signed [qte_pkg::W_ANG-1:0]  a,
        input logic signed [qte_pkg::W_DEGP-1:0] p
    );
        logic signed [qte_pkg::W_DEGP-1:0] v;
        if (deg) begin
            v = (p + (qte_pkg::W_DEGP'(1) <<< 46)) >>> 47;
        end else begin
            v = (qte_pkg::W_DEGP'(a) + (qte_pkg::W_DEGP'(1) <<< 16)) >>> 17;
        end
        if (v > qte_pkg::W_DEGP'(32767)) begin
            return 16'h7fff;
        end else if (v < -qte_pkg::W_DEGP'(32768)) begin
            return 16'h8000;
        end
        return v[qte_pkg::W_OUT-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_valid) begin
            r_deg <= i_cfg_data;
        end
    end

    // advance everything unless a result is stuck at the output
    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: component products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xx <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[15:0]);
            r_yy <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
            r_zz <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]);
            r_wy <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[31:16]);
            r_zx <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[15:0]);
            r_zy <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[31:16]);
            r_wx <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[15:0]);
            r_wz <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[47:32]);
            r_xy <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[31:16]);
            r_yz <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[47:32]);
        end
    end

    // stage 2: rotation matrix terms
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s   <= (qte_pkg::W_SUM'(r_wy) + qte_pkg::W_SUM'(r_zx)) <<< 1;
            r_m12 <= (qte_pkg::W_SUM'(r_zy) - qte_pkg::W_SUM'(r_wx)) <<< 1;
            r_m22 <= qte_pkg::ONE_Q28 - ((qte_pkg::W_SUM'(r_xx) + qte_pkg::W_SUM'(r_yy)) <<< 1);
            r_yn  <= (qte_pkg::W_SUM'(r_wz) - qte_pkg::W_SUM'(r_xy)) <<< 1;
            r_yd  <= qte_pkg::ONE_Q28 - ((qte_pkg::W_SUM'(r_yy) + qte_pkg::W_SUM'(r_zz)) <<< 1);
            r_m21 <= (qte_pkg::W_SUM'(r_yz) + qte_pkg::W_SUM'(r_wx)) <<< 1;
            r_m11 <= qte_pkg::ONE_Q28 - ((qte_pkg::W_SUM'(r_xx) + qte_pkg::W_SUM'(r_zz)) <<< 1);
        end
    end

    // stage 3: squares of the terms that lie inside the unit range
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_s_small <= (r_s > -qte_pkg::ONE_Q28) && (r_s < qte_pkg::ONE_Q28);
            r3_m_small <= (r_m12 > -qte_pkg::ONE_Q28) && (r_m12 < qte_pkg::ONE_Q28) &&
                          (r_m22 > -qte_pkg::ONE_Q28) && (r_m22 < qte_pkg::ONE_Q28);
            r3_ssq   <= $signed(r_s[28:0])   * $signed(r_s[28:0]);
            r3_m12sq <= $signed(r_m12[28:0]) * $signed(r_m12[28:0]);
            r3_m22sq <= $signed(r_m22[28:0]) * $signed(r_m22[28:0]);
            r3_s   <= r_s;
            r3_m12 <= r_m12;
            r3_m22 <= r_m22;
            r3_yn  <= r_yn;
            r3_yd  <= r_yd;
            r3_m21 <= r_m21;
            r3_m11 <= r_m11;
        end
    end

    // stage 4: pick the branch and the square-root operands
    always_comb begin
        w_q    = r3_m12sq + r3_m22sq;
        w_then = r3_s_small && (r3_ssq < qte_pkg::HALF_Q56);
        w_big  = !r3_m_small || (w_q >= qte_pkg::ONE_Q56);
        w_norm = w_then || w_big || (w_q > qte_pkg::SMALL_COS_SQ);

        n_sqa.root = '0;
        n_sqb.root = '0;
        if (w_then) begin
            n_sqa.rem = qte_pkg::W_REM'(qte_pkg::ONE_Q56 - r3_ssq);
        end else if (w_big) begin
            n_sqa.rem = '0;
        end else begin
            n_sqa.rem = qte_pkg::W_REM'(qte_pkg::ONE_Q56 - w_q);
        end
        n_sqb.rem = w_big ? '0 : qte_pkg::W_REM'(w_q);

        n_tag.then_br    = w_then;
        n_tag.pitch_zero = !w_then && w_big;
        n_tag.pitch_neg  = !w_then && (r3_s <= 0);
        n_tag.yaw_zero   = !w_norm;

        n_ry = w_norm ? -r3_m12 : r3_m21;
        n_rx = w_norm ? r3_m22  : r3_m11;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqa <= n_sqa;
            r_sqb <= n_sqb;
            r_tag <= n_tag;
            r_ry  <= n_ry;
            r_rx  <= n_rx;
            r_yn4 <= r3_yn;
            r_yd4 <= r3_yd;
            r_s4  <= r3_s;
        end
    end

    // square-root cells, one root bit per cell
    assign w_sa[0] = r_sqa;
    assign w_sb[0] = r_sqb;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
        qte_sqrt_cell #(
            .K(SQ_CELLS - 1 - g)
        ) u_sqa (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_d  (w_sa[g]),
            .o_d  (w_sa[g+1])
        );
        qte_sqrt_cell #(
            .K(SQ_CELLS - 1 - g)
        ) u_sqb (
            .i_clk(i_clk),
            .i_en (w_en),
            .i_d  (w_sb[g]),
            .o_d  (w_sb[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dtag[0] <= r_tag;
            r_dry[0]  <= r_ry;
            r_drx[0]  <= r_rx;
            r_dyn[0]  <= r_yn4;
            r_dyd[0]  <= r_yd4;
            r_ds[0]   <= r_s4;
            for (int k = 1; k < SQ_CELLS; k++) begin
                r_dtag[k] <= r_dtag[k-1];
                r_dry[k]  <= r_dry[k-1];
                r_drx[k]  <= r_drx[k-1];
                r_dyn[k]  <= r_dyn[k-1];
                r_dyd[k]  <= r_dyd[k-1];
                r_ds[k]   <= r_ds[k-1];
            end
            r_ctag[0] <= r_dtag[SQ_CELLS-1];
            for (int k = 1; k <= CORDIC_STAGES; k++) begin
                r_ctag[k] <= r_ctag[k-1];
            end
        end
    end

    // pitch operands: asin form or acos form
    assign w_ra = $signed({{(qte_pkg::W_SUM - qte_pkg::W_ROOT){1'b0}}, w_sa[SQ_CELLS].root});
    assign w_rb = $signed({{(qte_pkg::W_SUM - qte_pkg::W_ROOT){1'b0}}, w_sb[SQ_CELLS].root});
    assign w_py = r_dtag[SQ_CELLS-1].then_br ? r_ds[SQ_CELLS-1] : w_ra;
    assign w_px = r_dtag[SQ_CELLS-1].then_br ? w_ra : w_rb;

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(w_en),
        .i_y(r_dry[SQ_CELLS-1]), .i_x(r_drx[SQ_CELLS-1]), .o_z(w_zr)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(w_en),
        .i_y(w_py), .i_x(w_px), .o_z(w_zp)
    );
    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_en),
        .i_y(r_dyn[SQ_CELLS-1]), .i_x(r_dyd[SQ_CELLS-1]), .o_z(w_zy)
    );

    // sign and gimbal-lock fixups, degree scaling, rounding
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out[k] = scale_out(r_deg, r_ang[k], r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fix[0] <= w_zr;
            if (r_ctag[CORDIC_STAGES].pitch_zero) begin
                r_fix[1] <= '0;
            end else if (r_ctag[CORDIC_STAGES].pitch_neg) begin
                r_fix[1] <= -w_zp;
            end else begin
                r_fix[1] <= w_zp;
            end
            r_fix[2] <= r_ctag[CORDIC_STAGES].yaw_zero ? '0 : w_zy;
            for (int k = 0; k < 3; k++) begin
                r_ang[k]  <= r_fix[k];
                r_prod[k] <= r_fix[k] * qte_pkg::DEG_MUL;
                r_out[k]  <= n_out[k];
            end
        end
    end

    assign m_axis_tdata = {r_out[2], r_out[1], r_out[0]};

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld) && $stable(r_out[0]) && $stable(r_out[1]))
        else $error("pipeline moved during a stall");

    a_yaw_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_ctag[CORDIC_STAGES].yaw_zero |=> r_fix[2] == '0)
        else $error("yaw not cleared in gimbal lock");

    a_pitch_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_ctag[CORDIC_STAGES].pitch_zero |=> r_fix[1] == '0)
        else $error("pitch not cleared for out-of-range cosine");

endmodule

// File: bench/qte_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qte_checker: angle predictor and result comparison
// Watches the quaternion and angle streams and the mode writes, computes the
// expected roll, pitch and yaw for every quaternion transfer and compares
// them in order with the angles the converter delivers.
// ----------------------------------------------------------------------------
module qte_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    localparam longint ONE28 = 64'sd1 << 28;
    localparam longint PI_U = 64'sd3373259426;
    localparam longint HPI_U = 64'sd1686629713;
    localparam longint DEG_K = 64'sd961263669;
    localparam longint ATAN_U [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    logic    degrees_mode;
    t_angles angles_due [$];

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint acc, t, dx, dy;
        int n;
        acc = 0;
        n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
        if (yv == 0) return (xv >= 0) ? 0 : PI_U;
        if (xv < 0) begin
            t = xv;
            if (yv > 0) begin
                xv = yv; yv = -t; acc = HPI_U;
            end else begin
                xv = -yv; yv = t; acc = -HPI_U;
            end
        end
        for (int i = 0; i < n; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv += dx; yv -= dy; acc += ATAN_U[i];
            end else begin
                xv -= dx; yv += dy; acc -= ATAN_U[i];
            end
        end
        return acc;
    endfunction

    function automatic logic [15:0] scale_angle(longint a, logic deg);
        longint v;
        if (deg) v = (a * DEG_K + (64'sd1 << 46)) >>> 47;
        else v = (a + (64'sd1 << 16)) >>> 17;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_angles euler_of(logic [63:0] d, logic deg);
        longint x, y, z, w, s, m12, m22, yn, yd, r, p, yw, sn, cs;
        longint unsigned q, ss;
        logic big;
        t_angles e;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        w = longint'($signed(d[63:48]));
        s = 2 * (w * y + z * x);
        m12 = 2 * (z * y - w * x);
        m22 = ONE28 - 2 * (x * x + y * y);
        yn = 2 * (w * z - x * y);
        yd = ONE28 - 2 * (y * y + z * z);
        ss = s * s;
        if (mag(s) < ONE28 && ss < (64'd1 << 55)) begin
            r = vector_angle(-m12, m22);
            p = vector_angle(s, longint'(floor_sqrt((64'd1 << 56) - ss)));
            yw = vector_angle(yn, yd);
        end else begin
            big = 0;
            q = 0;
            if (mag(m12) >= ONE28 || mag(m22) >= ONE28) begin
                big = 1;
            end else begin
                q = m12 * m12 + m22 * m22;
                if (q >= (64'd1 << 56)) big = 1;
            end
            if (big) begin
                p = 0;
            end else begin
                sn = longint'(floor_sqrt((64'd1 << 56) - q));
                cs = longint'(floor_sqrt(q));
                p = vector_angle(sn, cs);
            end
            if (s <= 0) p = -p;
            if (big || q > 64'd7205759403792) begin
                r = vector_angle(-m12, m22);
                yw = vector_angle(yn, yd);
            end else begin
                r = vector_angle(2 * (y * z + x * w), ONE28 - 2 * (x * x + z * z));
                yw = 0;
            end
        end
        e.roll = scale_angle(r, deg);
        e.pitch = scale_angle(p, deg);
        e.yaw = scale_angle(yw, deg);
        return e;
    endfunction

    assign o_pending = angles_due.size();

    always @(posedge i_clk) begin
        t_angles got, want;
        if (!i_rst_n) begin
            degrees_mode <= 1'b0;
            angles_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) degrees_mode <= i_cfg_data;
            if (i_in_valid && i_in_ready)
                angles_due.push_back(euler_of(i_in_data, degrees_mode));
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (angles_due.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angles_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: roll exp %0d got %0d, pitch exp %0d got %0d, yaw exp %0d got %0d",
                                 $time, want.roll, got.roll, want.pitch, got.pitch,
                                 want.yaw, got.yaw);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: quaternion to Euler converter testbench
// Drives directed and random quaternions in both angle units with random
// idling on both streams, a long output hold-off and a drain pause; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY = 16 + 37;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // comp_x, comp_y, comp_z, comp_w
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off;

    quaternion_to_euler_angles_core #(.CORDIC_STAGES(16)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    qte_checker #(.CORDIC_STAGES(16)) i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) m_axis_tready <= 1'b0;
            else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one transfer; valid stays up so the next call can follow directly
    task automatic send_quat(logic [63:0] q);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= q;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_then_set(logic deg);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= deg;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // roughly unit quaternion: the normal operating region
    function automatic logic [63:0] unit_quat();
        real a, b, c, d, n;
        a = $itor($signed(16'($urandom)));
        b = $itor($signed(16'($urandom)));
        c = $itor($signed(16'($urandom)));
        d = $itor($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        return {16'($rtoi(d / n * 16384.0)), 16'($rtoi(c / n * 16384.0)),
                16'($rtoi(b / n * 16384.0)), 16'($rtoi(a / n * 16384.0))};
    endfunction

    // quaternion near gimbal lock: pitch close to +-90 degrees
    function automatic logic [63:0] lock_quat();
        logic signed [15:0] e;
        e = 16'($signed($urandom_range(60)) - 30);
        if ($urandom_range(1)) return {16'(11585 + e), 16'(0), 16'(11585 - e), 16'(0)};
        return {16'(11585), 16'(-11585 + e), 16'(e), 16'(11585)};
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1: send_quat({rand_comp(), rand_comp(), rand_comp(), rand_comp()});
                2: send_quat(lock_quat());
                default: send_quat(unit_quat());
            endcase
        end
    endtask

    initial begin
        logic [63:0] directed [$];
        hold_off = 1'b0;
        send_idle_pct = 22;
        recv_idle_pct = 69;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed = '{
            64'h4000_0000_0000_0000,   // identity
            64'h0000_0000_0000_0000,   // zero quaternion
            64'hC000_0000_0000_0000,   // negated identity
            64'h2d41_0000_2d41_0000,   // pitch +90
            64'h2d41_0000_d2bf_0000,   // pitch -90
            64'h2d41_0000_0000_2d41,   // roll 90
            64'h0000_0000_0000_4000,   // roll 180
            64'h2d41_2d41_0000_0000,   // yaw 90
            64'h0000_4000_0000_0000,   // yaw 180
            64'h7fff_7fff_7fff_7fff,
            64'h8000_8000_8000_8000,
            64'h7fff_8000_7fff_8000,
            64'h8000_7fff_8000_7fff,
            64'h0000_7fff_0000_0000,
            64'h0000_0000_8000_0000,
            64'h2d41_2d41_2d41_2d41,
            64'h1000_0000_0000_0000,   // non-unit
            64'h2000_0000_2000_0001,
            64'h2d41_0001_2d41_0001,   // near lock, small cosine
            64'hffff_ffff_ffff_ffff,
            64'h0001_0001_0001_0001
        };
        drain_then_set(1'b0);
        foreach (directed[i]) send_quat(directed[i]);
        drain_then_set(1'b1);
        foreach (directed[i]) send_quat(directed[i]);

        random_phase(250);
        // fill the pipeline against a stalled receiver
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_phase(120);
        join
        drain_then_set(1'b0);
        send_idle_pct = 69;
        recv_idle_pct = 22;
        random_phase(220);
        // pause until everything is out, then resume
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(100);
        drain_then_set(1'b1);
        random_phase(120);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
src/qte_pkg.sv
src/qte_sqrt_cell.sv
src/qte_cordic_cell.sv
src/qte_cordic.sv
src/quaternion_to_euler_angles_core.sv
bench/qte_checker.sv
bench/tb_top.sv
